// ----- src/mvt_pkg.sv -----
// shared types and constants for the 4x4 matrix-vector transform
package mvt_pkg;

  localparam int DIM    = 4;
  localparam int NREGS  = 8;
  localparam int WORD_W = 32;
  localparam int REG_W  = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;
  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [REG_W-1:0]         cfg_reg_t;

  // per-stage load enables shared by all four lanes
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic out_en;
  } lane_ctl_t;

endpackage

// ----- src/mvt_cfg.sv -----
// coefficient register file behind the apb-style port
module mvt_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvt_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvt_pkg::REG_W-1:0]    pwdata,
  output logic [mvt_pkg::REG_W-1:0]    prdata,
  output logic                         pready,
  output mvt_pkg::word_t               coef [mvt_pkg::DIM][mvt_pkg::DIM]
);

  localparam mvt_pkg::cfg_reg_t ONE_LO = mvt_pkg::REG_W'(1) << FRAC_BITS;
  localparam mvt_pkg::cfg_reg_t ONE_HI = ONE_LO << mvt_pkg::WORD_W;

  mvt_pkg::cfg_reg_t regs [mvt_pkg::NREGS];
  logic [mvt_pkg::IDX_W-1:0] idx;
  logic wr;

  assign idx    = paddr[mvt_pkg::ADDR_W-1:mvt_pkg::ADDR_W-mvt_pkg::IDX_W];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      // identity matrix
      regs[mvt_pkg::REG_ROW0_COLS01] <= ONE_LO;
      regs[mvt_pkg::REG_ROW0_COLS23] <= '0;
      regs[mvt_pkg::REG_ROW1_COLS01] <= ONE_HI;
      regs[mvt_pkg::REG_ROW1_COLS23] <= '0;
      regs[mvt_pkg::REG_ROW2_COLS01] <= '0;
      regs[mvt_pkg::REG_ROW2_COLS23] <= ONE_LO;
      regs[mvt_pkg::REG_ROW3_COLS01] <= '0;
      regs[mvt_pkg::REG_ROW3_COLS23] <= ONE_HI;
    end else if (wr) begin
      regs[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        if (c % 2 == 1) begin
          coef[r][c] = regs[mvt_pkg::IDX_W'(2*r + c/2)][mvt_pkg::REG_W-1:mvt_pkg::WORD_W];
        end else begin
          coef[r][c] = regs[mvt_pkg::IDX_W'(2*r + c/2)][mvt_pkg::WORD_W-1:0];
        end
      end
    end
  end

endmodule

// ----- src/mvt_lane.sv -----
// one matrix row: four multipliers, pairwise adds, final add with shift and saturation
module mvt_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  mvt_pkg::lane_ctl_t  ctl,
  input  mvt_pkg::word_t      coef [mvt_pkg::DIM],
  input  mvt_pkg::word_t      vec  [mvt_pkg::DIM],
  output mvt_pkg::word_t      res
);

  localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_MIN = -66'sd2147483648;

  logic signed [mvt_pkg::PROD_W-1:0] prod [mvt_pkg::DIM];
  logic signed [mvt_pkg::PAIR_W-1:0] pair [2];
  logic signed [mvt_pkg::SUM_W-1:0]  sum;
  logic signed [mvt_pkg::SUM_W-1:0]  shifted;
  mvt_pkg::word_t                    res_next;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod[c] <= coef[c] * vec[c];
      end
    end
    if (ctl.add_en) begin
      pair[0] <= mvt_pkg::PAIR_W'(prod[0]) + mvt_pkg::PAIR_W'(prod[1]);
      pair[1] <= mvt_pkg::PAIR_W'(prod[2]) + mvt_pkg::PAIR_W'(prod[3]);
    end
    if (ctl.out_en) begin
      res <= res_next;
    end
  end

  // full-precision sum, floor shift, clamp to 32 bits
  always_comb begin
    sum     = mvt_pkg::SUM_W'(pair[0]) + mvt_pkg::SUM_W'(pair[1]);
    shifted = sum >>> FRAC_BITS;
    if (shifted > SAT_MAX) begin
      res_next = SAT_MAX[mvt_pkg::WORD_W-1:0];
    end else if (shifted < SAT_MIN) begin
      res_next = SAT_MIN[mvt_pkg::WORD_W-1:0];
    end else begin
      res_next = shifted[mvt_pkg::WORD_W-1:0];
    end
  end

endmodule

// ----- src/matrix_vector_transform_4x4.sv -----
// top level: 4x4 q16.16 matrix-vector transform, four row lanes merged into one result
//
//   channel  handshake              payload
//   input    in_valid / in_stall    vx vy vz vw
//   output   out_valid / out_stall  rx ry rz rw
//   config   apb psel/penable       paddr[5:3] selects one of eight 64-bit registers
//
// one vector per cycle sustained when not stalled; stages: input register, multiplier
// stage, pairwise add stage, final add/shift/saturate into the output register.
// synchronous reset empties the pipeline and loads the identity matrix.
// a stalled output holds; bubbles collapse, so in_stall only rises once all
// four stages hold a transaction.
module matrix_vector_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mvt_pkg::word_t             vx,
  input  mvt_pkg::word_t             vy,
  input  mvt_pkg::word_t             vz,
  input  mvt_pkg::word_t             vw,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mvt_pkg::word_t             rx,
  output mvt_pkg::word_t             ry,
  output mvt_pkg::word_t             rz,
  output mvt_pkg::word_t             rw,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvt_pkg::ADDR_W-1:0] paddr,
  input  logic [mvt_pkg::REG_W-1:0]  pwdata,
  output logic [mvt_pkg::REG_W-1:0]  prdata,
  output logic                       pready
);

  mvt_pkg::word_t     coef [mvt_pkg::DIM][mvt_pkg::DIM];
  mvt_pkg::word_t     vec  [mvt_pkg::DIM];
  mvt_pkg::word_t     res  [mvt_pkg::DIM];
  mvt_pkg::lane_ctl_t ctl;

  logic valid0, valid1, valid2, valid3;
  logic free0, free1, free2, free3;

  mvt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // a stage can load when it is empty or its content moves on this cycle
  assign free3    = !valid3 || !out_stall;
  assign free2    = !valid2 || free3;
  assign free1    = !valid1 || free2;
  assign free0    = !valid0 || free1;
  assign in_stall = !free0;

  assign ctl.mul_en = free1;
  assign ctl.add_en = free2;
  assign ctl.out_en = free3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (free0) valid0 <= in_valid;
      if (free1) valid1 <= valid0;
      if (free2) valid2 <= valid1;
      if (free3) valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (free0) begin
      vec[0] <= vx;
      vec[1] <= vy;
      vec[2] <= vz;
      vec[3] <= vw;
    end
  end

  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_lane
    mvt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef[r]),
      .vec  (vec),
      .res  (res[r])
    );
  end

  assign out_valid = valid3;
  assign rx        = res[0];
  assign ry        = res[1];
  assign rz        = res[2];
  assign rw        = res[3];

endmodule

// ----- tb/matrix_vector_transform_4x4_tb.sv -----
// testbench for the 4x4 q16.16 matrix-vector transform: directed and random vectors
module matrix_vector_transform_4x4_tb;

  localparam int FRAC_BITS       = 16;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 8;
  localparam string RESULT_FIELDS [mvt_pkg::DIM] = '{"rx", "ry", "rz", "rw"};

  // component 0 is x, component 3 is w
  typedef logic [mvt_pkg::DIM-1:0][mvt_pkg::WORD_W-1:0] vec4_t;

  class mvt_scoreboard;
    mvt_pkg::cfg_reg_t coef_regs [mvt_pkg::NREGS];
    vec4_t             expected_q [$];
    int                failures;

    function new();
      failures = 0;
      foreach (coef_regs[i]) coef_regs[i] = '0;
      coef_regs[mvt_pkg::REG_ROW0_COLS01] = mvt_pkg::cfg_reg_t'(1) << FRAC_BITS;
      coef_regs[mvt_pkg::REG_ROW1_COLS01] =
        mvt_pkg::cfg_reg_t'(1) << (FRAC_BITS + mvt_pkg::WORD_W);
      coef_regs[mvt_pkg::REG_ROW2_COLS23] = mvt_pkg::cfg_reg_t'(1) << FRAC_BITS;
      coef_regs[mvt_pkg::REG_ROW3_COLS23] =
        mvt_pkg::cfg_reg_t'(1) << (FRAC_BITS + mvt_pkg::WORD_W);
    endfunction

    function void set_reg(logic [mvt_pkg::IDX_W-1:0] idx, mvt_pkg::cfg_reg_t val);
      coef_regs[idx] = val;
    endfunction

    // exact sum of four products, floor shift, then clamp to 32 bits
    function mvt_pkg::word_t row_dot(int row, vec4_t v);
      logic signed [mvt_pkg::SUM_W-1:0]  acc;
      logic signed [mvt_pkg::PROD_W-1:0] prod;
      mvt_pkg::cfg_reg_t                 pair;
      mvt_pkg::word_t                    c;
      acc = '0;
      for (int col = 0; col < mvt_pkg::DIM; col++) begin
        pair = coef_regs[2 * row + col / 2];
        c = (col % 2 == 1) ? pair[mvt_pkg::REG_W-1:mvt_pkg::WORD_W]
                           : pair[mvt_pkg::WORD_W-1:0];
        prod = c * $signed(v[col]);
        acc += prod;
      end
      acc = acc >>> FRAC_BITS;
      if (acc[mvt_pkg::SUM_W-1:mvt_pkg::WORD_W-1] !=
          {(mvt_pkg::SUM_W-mvt_pkg::WORD_W+1){acc[mvt_pkg::SUM_W-1]}})
        return acc[mvt_pkg::SUM_W-1] ? mvt_pkg::word_t'(32'h8000_0000)
                                     : mvt_pkg::word_t'(32'h7fff_ffff);
      return acc[mvt_pkg::WORD_W-1:0];
    endfunction

    function void note_input(vec4_t v);
      vec4_t r;
      for (int i = 0; i < mvt_pkg::DIM; i++) r[i] = row_dot(i, v);
      expected_q.push_back(r);
    endfunction

    function void check_result(vec4_t got);
      vec4_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: rx=%0d ry=%0d rz=%0d rw=%0d",
               $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
        failures++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
        if (got[i] !== want[i]) begin
          $error("%s mismatch: expected %0d, got %0d", RESULT_FIELDS[i],
                 $signed(want[i]), $signed(got[i]));
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       out_stall = 1'b0;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [mvt_pkg::ADDR_W-1:0] paddr     = '0;
  mvt_pkg::cfg_reg_t          pwdata    = '0;
  mvt_pkg::word_t             vx = '0, vy = '0, vz = '0, vw = '0;
  logic                       in_stall, out_valid, pready;
  mvt_pkg::word_t             rx, ry, rz, rw;
  mvt_pkg::cfg_reg_t          prdata;

  mvt_scoreboard     sb = new();
  mvt_pkg::cfg_reg_t matrix_regs [mvt_pkg::NREGS];
  int                in_run_left  = 0;
  bit                in_quiet     = 1'b0;
  int                out_run_left = 0;
  bit                out_quiet    = 1'b0;
  int                quiet_cycles = 0;

  matrix_vector_transform_4x4 #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vx(vx), .vy(vy), .vz(vz), .vw(vw),
    .out_valid(out_valid), .out_stall(out_stall),
    .rx(rx), .ry(ry), .rz(rz), .rw(rw),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // each run is either back-to-back traffic or random gaps, picked at random
  function int idle_draw(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 40);
      quiet = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  function mvt_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          4: return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      // within +-256.0
      default: return mvt_pkg::word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // style 0 mostly small coefficients, 1 mostly full range, 2 leans on extremes
  function mvt_pkg::word_t rand_coef(int style);
    int pick;
    pick = $urandom_range(0, 9);
    if ((style == 2 && pick < 6) || pick == 0) begin
      case ($urandom_range(0, 5))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        4: return 32'h0001_0000;
        default: return 32'hffff_0000;
      endcase
    end
    if (style == 1 && pick < 7) return $urandom;
    return mvt_pkg::word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  task send_vector(input mvt_pkg::word_t x, input mvt_pkg::word_t y,
                   input mvt_pkg::word_t z, input mvt_pkg::word_t w);
    int gap;
    bit taken;
    gap = idle_draw(in_run_left, in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vx <= x;
    vy <= y;
    vz <= z;
    vw <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task finish_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task program_matrix();
    for (int i = 0; i < mvt_pkg::NREGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {mvt_pkg::IDX_W'(i), 3'b000};
      pwdata  <= matrix_regs[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_reg(mvt_pkg::IDX_W'(i), matrix_regs[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver: stall for a drawn number of cycles ahead of each result
  initial begin
    int  hold;
    bit  got;
    forever begin
      hold = idle_draw(out_run_left, out_quiet);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = !rst && out_valid;
        @(posedge clk);
      end while (!got);
    end
  end

  // sample mid-cycle: values here are the ones seen at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input({vw, vz, vy, vx});
      if (out_valid && !out_stall) sb.check_result({rw, rz, ry, rx});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // identity from reset: results equal the inputs
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_vector(32'h1234_5678, 32'hedcb_a987, 32'h0001_0000, 32'hffff_0000);
    finish_phase();

    // largest positive coefficients: saturation both ways
    foreach (matrix_regs[i]) matrix_regs[i] = {2{32'h7fff_ffff}};
    program_matrix();
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    finish_phase();

    // most negative coefficients: the full-width sum reaches 2**64
    foreach (matrix_regs[i]) matrix_regs[i] = {2{32'h8000_0000}};
    program_matrix();
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    finish_phase();

    // tiny coefficients: sub-lsb sums, negative ones floor to -1
    matrix_regs[mvt_pkg::REG_ROW0_COLS01] = {32'h0000_0000, 32'h0000_0001};
    matrix_regs[mvt_pkg::REG_ROW0_COLS23] = '0;
    matrix_regs[mvt_pkg::REG_ROW1_COLS01] = {32'h0000_0000, 32'hffff_ffff};
    matrix_regs[mvt_pkg::REG_ROW1_COLS23] = '0;
    matrix_regs[mvt_pkg::REG_ROW2_COLS01] = {32'h0000_0001, 32'h0000_0001};
    matrix_regs[mvt_pkg::REG_ROW2_COLS23] = {32'h0000_0001, 32'h0000_0001};
    matrix_regs[mvt_pkg::REG_ROW3_COLS01] = {32'hffff_0000, 32'h0001_0000};
    matrix_regs[mvt_pkg::REG_ROW3_COLS23] = {32'hffff_8000, 32'h0000_8000};
    program_matrix();
    send_vector(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vector(32'h0000_ffff, 32'h0000_0001, 32'h0000_0003, 32'hffff_fffd);
    finish_phase();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      foreach (matrix_regs[i]) matrix_regs[i] = {rand_coef(ph % 3), rand_coef(ph % 3)};
      program_matrix();
      repeat (ITEMS_PER_PHASE)
        send_vector(rand_word(), rand_word(), rand_word(), rand_word());
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- matrix_vector_transform_4x4.f -----
src/mvt_pkg.sv
src/mvt_cfg.sv
src/mvt_lane.sv
src/matrix_vector_transform_4x4.sv
tb/matrix_vector_transform_4x4_tb.sv
